FILE: sv/assert_macros.svh
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, skipped while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/mbd_pkg.sv
// Types and constants shared by the mipmap box downsampler files.
package mbd_pkg;

    localparam int PIX_W  = 8;
    localparam int SUM_W  = 9;
    localparam int DIM_W  = 13;
    localparam int ROW_W  = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [DIM_W-1:0] HEIGHT_LIMIT = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 1'b1;

    // Horizontal pair sums of one column pair, one 9-bit sum per channel.
    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_pair_sum;

endpackage

FILE: sv/mipmap_box_downsampler.sv
// Top level of the 2x2 box-filter mipmap downsampler.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | sink      | i_in_valid / o_in_stall    | i_red_in, i_green_in, i_blue_in
//  out     | source    | o_out_valid / i_out_stall  | o_red_out, o_green_out, o_blue_out,
//          |           |                            | o_level_done
//  cfg     | sink      | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One source pixel is accepted per cycle unless o_in_stall is high; a block's result is
// registered in stage 1, with the registered line store read, then in the output register.
// Reset clears counters, dimensions and valids; the line store is not cleared and
// needs no pass, since an odd row only reads entries its even row wrote.
// A stalled result sits in the output register while one more waits behind it;
// o_in_stall rises only when both are full.
module mipmap_box_downsampler #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mbd_pkg::DIM_W-1:0]            i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [mbd_pkg::PIX_W-1:0]            i_red_in,
    input  logic [mbd_pkg::PIX_W-1:0]            i_green_in,
    input  logic [mbd_pkg::PIX_W-1:0]            i_blue_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [mbd_pkg::PIX_W-1:0]            o_red_out,
    output logic [mbd_pkg::PIX_W-1:0]            o_green_out,
    output logic [mbd_pkg::PIX_W-1:0]            o_blue_out,
    output logic                                 o_level_done
);

    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int DW         = mbd_pkg::DIM_W;
    localparam int SW         = mbd_pkg::SUM_W;
    localparam int TW         = mbd_pkg::SUM_W + 1;

    // configuration, stored already clamped
    logic [WW-1:0]  r_w;
    logic [DW-1:0]  r_h;
    logic [WW-1:0]  n_w;
    logic [DW-1:0]  n_h;
    logic [31:0]    cfg_ext;

    // position of the next source pixel
    logic [CW-1:0]             r_col;
    logic [mbd_pkg::ROW_W-1:0] r_row;
    logic [mbd_pkg::PIX_W-1:0] r_even_red, r_even_green, r_even_blue;

    // stage 1 and output register
    logic               r_s1_valid;
    mbd_pkg::t_pair_sum r_s1_sum;
    logic               r_s1_add_line;
    logic [1:0]         r_s1_shift;
    logic               r_s1_done;
    logic               r_out_valid;
    logic [mbd_pkg::PIX_W-1:0] r_out_red, r_out_green, r_out_blue;
    logic               r_out_done;

    logic          accept, s1_move;
    logic          hx2, vy2, col_in, row_in, active, col_odd, row_odd;
    logic          take_even, pair_ready, line_wr, line_rd, emit, done;
    logic          col_last, row_last;
    logic [WW-1:0] w_even;
    logic [DW-1:0] h_even;
    logic [1:0]    shift;
    logic [AW-1:0] line_addr;
    mbd_pkg::t_pair_sum pair_sum, line_data;
    logic [TW-1:0] tot_red, tot_green, tot_blue;

    // clamp a written width to 1..MAX_WIDTH and a height to 1..HEIGHT_LIMIT
    always_comb begin
        cfg_ext = 32'(i_cfg_data);
        if (cfg_ext == 32'd0) begin
            n_w = WW'(1);
        end else if (cfg_ext > 32'(MAX_WIDTH)) begin
            n_w = WW'(MAX_WIDTH);
        end else begin
            n_w = WW'(cfg_ext);
        end
        if (i_cfg_data == '0) begin
            n_h = DW'(1);
        end else if (i_cfg_data > mbd_pkg::HEIGHT_LIMIT) begin
            n_h = mbd_pkg::HEIGHT_LIMIT;
        end else begin
            n_h = i_cfg_data;
        end
    end

    assign o_in_stall = r_s1_valid && r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);

    // classify the incoming pixel
    always_comb begin
        hx2     = (r_w != WW'(1));
        vy2     = (r_h != DW'(1));
        w_even  = {r_w[WW-1:1], 1'b0};
        h_even  = {r_h[DW-1:1], 1'b0};
        col_odd = r_col[0];
        row_odd = r_row[0];
        col_in  = !hx2 || (WW'(r_col) < w_even);
        row_in  = !vy2 || (DW'(r_row) < h_even);
        active  = accept && (hx2 || vy2) && col_in && row_in;

        take_even  = active && hx2 && !col_odd;
        pair_ready = active && !(hx2 && !col_odd);
        line_wr    = pair_ready && vy2 && !row_odd;
        emit       = pair_ready && (!vy2 || row_odd);
        line_rd    = emit && vy2;

        done  = (!hx2 || (WW'(r_col) == w_even - WW'(1)))
             && (!vy2 || (DW'(r_row) == h_even - DW'(1)));
        shift = {1'b0, hx2} + {1'b0, vy2};

        pair_sum.red   = SW'(i_red_in)   + (hx2 ? SW'(r_even_red)   : '0);
        pair_sum.green = SW'(i_green_in) + (hx2 ? SW'(r_even_green) : '0);
        pair_sum.blue  = SW'(i_blue_in)  + (hx2 ? SW'(r_even_blue)  : '0);

        line_addr = AW'(r_col >> 1);

        col_last = (WW'(r_col) == r_w - WW'(1));
        row_last = (DW'(r_row) == r_h - DW'(1));
    end

    mbd_line_store #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (line_wr),
        .i_rd_en   (line_rd),
        .i_addr    (line_addr),
        .i_wr_data (pair_sum),
        .o_rd_data (line_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w          <= WW'(1);
            r_h          <= DW'(1);
            r_col        <= '0;
            r_row        <= '0;
            r_even_red   <= '0;
            r_even_green <= '0;
            r_even_blue  <= '0;
        end else begin
            if (i_cfg_we) begin
                // any register write restarts the level
                case (i_cfg_index)
                    mbd_pkg::REG_SRC_WIDTH:  r_w <= n_w;
                    mbd_pkg::REG_SRC_HEIGHT: r_h <= n_h;
                    default: ;
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (take_even) begin
                r_even_red   <= i_red_in;
                r_even_green <= i_green_in;
                r_even_blue  <= i_blue_in;
            end
        end
    end

    // stage 1: block sum waits for the line store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= emit;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
        if (emit) begin
            r_s1_sum      <= pair_sum;
            r_s1_add_line <= vy2;
            r_s1_shift    <= shift;
            r_s1_done     <= done;
        end
    end

    always_comb begin
        tot_red   = TW'(r_s1_sum.red)   + (r_s1_add_line ? TW'(line_data.red)   : '0);
        tot_green = TW'(r_s1_sum.green) + (r_s1_add_line ? TW'(line_data.green) : '0);
        tot_blue  = TW'(r_s1_sum.blue)  + (r_s1_add_line ? TW'(line_data.blue)  : '0);
    end

    // output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (s1_move) begin
            r_out_red   <= mbd_pkg::PIX_W'(tot_red   >> r_s1_shift);
            r_out_green <= mbd_pkg::PIX_W'(tot_green >> r_s1_shift);
            r_out_blue  <= mbd_pkg::PIX_W'(tot_blue  >> r_s1_shift);
            r_out_done  <= r_s1_done;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_red_out    = r_out_red;
    assign o_green_out  = r_out_green;
    assign o_blue_out   = r_out_blue;
    assign o_level_done = r_out_done;

endmodule

FILE: sv/mbd_line_store.sv
// Line store for the pair sums of an even source row, one port, registered read.
module mbd_line_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_addr,
    input  mbd_pkg::t_pair_sum i_wr_data,
    output mbd_pkg::t_pair_sum o_rd_data
);

    mbd_pkg::t_pair_sum r_mem [DEPTH];
    mbd_pkg::t_pair_sum r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        // hold the read data until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/mbd_port_checker.sv
// Port-level checker for the mipmap box downsampler, bound to the top level.
`include "assert_macros.svh"

module mbd_port_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_stall,
    input logic                      i_out_valid,
    input logic                      i_out_stall,
    input logic [mbd_pkg::PIX_W-1:0] i_red_out,
    input logic [mbd_pkg::PIX_W-1:0] i_green_out,
    input logic [mbd_pkg::PIX_W-1:0] i_blue_out,
    input logic                      i_level_done
);

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall |=> i_out_valid && $stable(i_red_out) && $stable(i_green_out) && $stable(i_blue_out) && $stable(i_level_done), "stalled result changed")

    `ASSERT_CLK(a_in_stall_cause, i_clk, i_rst_n, i_in_stall |-> i_out_valid && i_out_stall, "input stalled without a stalled result")

    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid right after reset")

    `ASSERT_CLK(a_no_early_result, i_clk, i_rst_n, !$past(i_in_valid) && !$past(i_in_valid, 2) && !$past(i_out_valid) && $past(i_rst_n, 2) |-> !i_out_valid, "result without an input item")

endmodule

bind mipmap_box_downsampler mbd_port_checker u_port_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .i_in_stall   (o_in_stall),
    .i_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .i_red_out    (o_red_out),
    .i_green_out  (o_green_out),
    .i_blue_out   (o_blue_out),
    .i_level_done (o_level_done)
);
